// File: hw/rtl/kde_background_pixel_classifier_defines.svh
// Assertion macros for the pixel classifier RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef KDE_BACKGROUND_PIXEL_CLASSIFIER_DEFINES_SVH
`define KDE_BACKGROUND_PIXEL_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define KDE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("kde classifier check failed");
`define KDE_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("kde classifier reset check failed");
`else
`define KDE_ASSERT(lbl, prop)
`define KDE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/kde_pkg.sv
// Shared types, constants and the exp table of the pixel classifier.
// No dependencies.
package kde_pkg;

   localparam int PIXEL_COUNT  = 16384;
   localparam int SAMPLE_SLOTS = 10;
   localparam int PIX_AW       = $clog2(PIXEL_COUNT);
   localparam int SLOT_W       = $clog2(SAMPLE_SLOTS);

   localparam logic [1:0] OP_CLASSIFY = 2'd0;
   localparam logic [1:0] OP_SAMPLE   = 2'd1;
   localparam logic [1:0] OP_MEDIAN   = 2'd2;
   localparam logic [1:0] OP_WEIGHT   = 2'd3;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_UPDATE    = 2'd1;
   localparam logic [1:0] CSR_SLOT      = 2'd2;

   localparam logic [14:0] HALF_SQ_COEF = 15'd30325;
   localparam logic [14:0] NORM_COEF    = 15'd25150;

   // exponent argument bits; x at or above 2^X_BITS gives a zero kernel
   localparam int X_BITS     = 20;
   localparam int LANE_LAT   = 3 + 2 * X_BITS + 2;
   localparam int TREE_LVL   = $clog2(SAMPLE_SLOTS);
   localparam int DENS_BITS  = 16;
   localparam int DENS_LAT   = TREE_LVL + 2 + DENS_BITS;
   localparam int PIPE_DEPTH = 1 + LANE_LAT + DENS_LAT;
   localparam int TERM_W     = 48;
   localparam int SUM_W      = TERM_W + TREE_LVL;
   localparam int T_W        = SUM_W - 31 + 1;

   typedef struct packed {
      logic [1:0]  op;
      logic [13:0] pixel_index;
      logic [3:0]  slot;
      logic [7:0]  pixel_value;
      logic [7:0]  median_value;
      logic [15:0] slot_weight;
   } req_type;

   typedef struct packed {
      logic [15:0] density;
      logic        foreground;
      logic        sample_replaced;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  op;
      logic [13:0] pix;
      logic [7:0]  value;
      logic [7:0]  med;
      logic        pix_ok;
   } tag_type;

   typedef struct packed {
      logic              smp_we;
      logic [SLOT_W-1:0] smp_slot;
      logic [PIX_AW-1:0] smp_addr;
      logic [7:0]        smp_data;
      logic              med_we;
      logic [PIX_AW-1:0] med_addr;
      logic [7:0]        med_data;
   } store_wr_type;

   // Q16 exp(-2^(j-16))
   function automatic logic [15:0] exp_q16(input logic [4:0] j);
      logic [15:0] e;
      case (j)
         5'd0:  e = 16'd65535;
         5'd1:  e = 16'd65534;
         5'd2:  e = 16'd65532;
         5'd3:  e = 16'd65528;
         5'd4:  e = 16'd65520;
         5'd5:  e = 16'd65504;
         5'd6:  e = 16'd65472;
         5'd7:  e = 16'd65408;
         5'd8:  e = 16'd65280;
         5'd9:  e = 16'd65026;
         5'd10: e = 16'd64520;
         5'd11: e = 16'd63520;
         5'd12: e = 16'd61565;
         5'd13: e = 16'd57835;
         5'd14: e = 16'd51039;
         5'd15: e = 16'd39750;
         5'd16: e = 16'd24109;
         5'd17: e = 16'd8869;
         5'd18: e = 16'd1200;
         5'd19: e = 16'd22;
         default: e = 16'd0;
      endcase
      return e;
   endfunction

endpackage

// File: hw/rtl/kde_sample_store.sv
// Banked per-pixel sample memories (one bank per slot) and the median memory.
// Depends on kde_pkg.
module kde_sample_store (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [kde_pkg::PIX_AW-1:0]   rd_addr,
   input  kde_pkg::store_wr_type        wr,
   output logic [7:0]                   rd_sample [kde_pkg::SAMPLE_SLOTS],
   output logic [7:0]                   rd_median
);

   logic [7:0] sample_mem [kde_pkg::SAMPLE_SLOTS][kde_pkg::PIXEL_COUNT];
   logic [7:0] median_mem [kde_pkg::PIXEL_COUNT];
   logic [7:0] rd_sample_ff [kde_pkg::SAMPLE_SLOTS];
   logic [7:0] rd_median_ff;

   for (genvar b = 0; b < kde_pkg::SAMPLE_SLOTS; b++) begin : g_bank
      always_ff @(posedge clock) begin
         if (wr.smp_we && wr.smp_slot == kde_pkg::SLOT_W'(b)) begin
            sample_mem[b][wr.smp_addr] <= wr.smp_data;
         end
         if (rd_en) begin
            rd_sample_ff[b] <= sample_mem[b][rd_addr];
         end
      end
      assign rd_sample[b] = rd_sample_ff[b];
   end

   always_ff @(posedge clock) begin
      if (wr.med_we) begin
         median_mem[wr.med_addr] <= wr.med_data;
      end
      if (rd_en) begin
         rd_median_ff <= median_mem[rd_addr];
      end
   end

   assign rd_median = rd_median_ff;

endmodule

// File: hw/rtl/kde_lane.sv
// One kernel lane: distance, exponent argument by pipelined division,
// exp by per-bit table multiplies, weighting. Depends on kde_pkg.
module kde_lane (
   input  logic                         clock,
   input  logic                         en,
   input  logic [7:0]                   value,
   input  logic [7:0]                   sample,
   input  logic [7:0]                   med,
   input  logic [15:0]                  weight,
   output logic [kde_pkg::TERM_W-1:0]   term
);

   localparam int XB    = kde_pkg::X_BITS;
   localparam int NUM_W = 31;
   localparam int DIV_W = 16 + XB;

   logic [7:0]       abs_diff;
   logic [15:0]      d2_ff, m2_ff, m2b_ff;
   logic [NUM_W-1:0] num_ff;

   logic [NUM_W-1:0] rem_ff [XB+1];
   logic [XB-1:0]    q_ff   [XB+1];
   logic [15:0]      dv_ff  [XB+1];
   logic             sat_ff [XB+1];

   logic [16:0]      acc_src [XB+1];
   logic [XB-1:0]    x_src   [XB+1];
   logic [16:0]      acc_ff  [XB];
   logic [XB-1:0]    x_ff    [XB];

   logic [32:0]      p_ff;
   logic [kde_pkg::TERM_W-1:0] t_ff;

   assign abs_diff = (value >= sample) ? value - sample : sample - value;

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff     <= 16'(abs_diff) * 16'(abs_diff);
         m2_ff     <= 16'(med) * 16'(med);
         num_ff    <= NUM_W'(d2_ff) * NUM_W'(kde_pkg::HALF_SQ_COEF) + NUM_W'(m2_ff >> 1);
         m2b_ff    <= m2_ff;
         rem_ff[0] <= num_ff;
         q_ff[0]   <= '0;
         dv_ff[0]  <= m2b_ff;
         sat_ff[0] <= DIV_W'(num_ff) >= {m2b_ff, {XB{1'b0}}};
      end
   end

   // restoring division, one quotient bit a stage, most significant first
   for (genvar k = 0; k < XB; k++) begin : g_div
      localparam int J = XB - 1 - k;
      logic [DIV_W-1:0] shifted;
      logic             take;
      assign shifted = DIV_W'(dv_ff[k]) << J;
      assign take    = !sat_ff[k] && (DIV_W'(rem_ff[k]) >= shifted);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= take ? rem_ff[k] - NUM_W'(shifted) : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (XB'(take) << J);
            dv_ff[k+1]  <= dv_ff[k];
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   // a saturated argument starts from zero, which the multiplies keep at zero
   assign acc_src[0] = sat_ff[XB] ? 17'd0 : 17'h10000;
   assign x_src[0]   = q_ff[XB];

   for (genvar k = 0; k < XB; k++) begin : g_exp
      logic [33:0] prod;
      assign prod = 34'(acc_src[k]) * 34'(kde_pkg::exp_q16(5'(k))) + 34'd32768;
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= x_src[k][k] ? 17'(prod >> 16) : acc_src[k];
            x_ff[k]   <= x_src[k];
         end
      end
      assign acc_src[k+1] = acc_ff[k];
      assign x_src[k+1]   = x_ff[k];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= 33'(weight) * 33'(acc_src[XB]);
         t_ff <= kde_pkg::TERM_W'(p_ff) * kde_pkg::TERM_W'(kde_pkg::NORM_COEF);
      end
   end

   assign term = t_ff;

endmodule

// File: hw/rtl/kde_density.sv
// Registered adder tree over the lane terms, then the rounded division by
// the median with saturation. Depends on kde_pkg.
module kde_density (
   input  logic                         clock,
   input  logic                         en,
   input  logic [kde_pkg::TERM_W-1:0]   term [kde_pkg::SAMPLE_SLOTS],
   input  logic [7:0]                   med,
   output logic [15:0]                  dens
);

   localparam int LVL    = kde_pkg::TREE_LVL;
   localparam int LEAVES = 2 ** LVL;
   localparam int SW     = kde_pkg::SUM_W;
   localparam int TW     = kde_pkg::T_W;
   localparam int DB     = kde_pkg::DENS_BITS;

   logic [SW-1:0] src     [LVL+1][LEAVES];
   logic [SW-1:0] node_ff [LVL][LEAVES];
   logic [7:0]    med_src [LVL+1];
   logic [7:0]    med_ff  [LVL];

   logic [TW-1:0] t_ff;
   logic [7:0]    mt_ff;

   logic [TW-1:0] rem_ff [DB+1];
   logic [DB-1:0] q_ff   [DB+1];
   logic [7:0]    dv_ff  [DB+1];
   logic          sat_ff [DB+1];

   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < kde_pkg::SAMPLE_SLOTS) begin : g_used
         assign src[0][i] = SW'(term[i]);
      end else begin : g_pad
         assign src[0][i] = '0;
      end
   end
   assign med_src[0] = med;

   for (genvar l = 0; l < LVL; l++) begin : g_lvl
      for (genvar n = 0; n < LEAVES; n++) begin : g_node
         if (n < (LEAVES >> (l + 1))) begin : g_add
            always_ff @(posedge clock) begin
               if (en) begin
                  node_ff[l][n] <= src[l][2*n] + src[l][2*n+1];
               end
            end
         end else begin : g_zero
            always_ff @(posedge clock) begin
               if (en) begin
                  node_ff[l][n] <= '0;
               end
            end
         end
         assign src[l+1][n] = node_ff[l][n];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            med_ff[l] <= med_src[l];
         end
      end
      assign med_src[l+1] = med_ff[l];
   end

   // floor((floor(sum / 2^31) + m) / 2m) is the rounded sum / (m * 2^32)
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff      <= TW'(src[LVL][0] >> 31) + TW'(med_src[LVL]);
         mt_ff     <= med_src[LVL];
         rem_ff[0] <= t_ff;
         q_ff[0]   <= '0;
         dv_ff[0]  <= mt_ff;
         sat_ff[0] <= 32'(t_ff) >= (32'(mt_ff) << (DB + 1));
      end
   end

   for (genvar k = 0; k < DB; k++) begin : g_div
      localparam int J = DB - 1 - k;
      logic [31:0] shifted;
      logic        take;
      assign shifted = 32'(dv_ff[k]) << (J + 1);
      assign take    = !sat_ff[k] && (32'(rem_ff[k]) >= shifted);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= take ? rem_ff[k] - TW'(shifted) : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (DB'(take) << J);
            dv_ff[k+1]  <= dv_ff[k];
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   assign dens = sat_ff[DB] ? {DB{1'b1}} : q_ff[DB];

endmodule

// File: hw/rtl/kde_background_pixel_classifier.sv
// Top level of the kernel density background pixel classifier: control,
// hazard interlock, weights, registers. Depends on kde_pkg, kde_sample_store,
// kde_lane, kde_density and the assertion macro header.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_item  (kde_pkg::req_type)
//   rsp      out        rsp_valid / rsp_stall   rsp_item  (kde_pkg::rsp_type)
//   csr      in         csr_we                  csr_index, csr_wdata
//
// One item a cycle while the pipeline is not held; each item's result passes through
// the memory read with the accepting edge, then 45 lane stages, 22 density stages
// and the output register.
// The whole pipeline moves when the output register is empty or taken.
// An item is held back while a classify of the same pixel is in flight (its
// sample write-back comes at the end), a weight load waits for an empty
// pipeline, and a sample load waits while a write-back uses the port.
// Reset clears the valid bits and presets the control registers only; the memories need no clearing.
`include "kde_background_pixel_classifier_defines.svh"

module kde_background_pixel_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kde_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kde_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int N     = kde_pkg::PIPE_DEPTH;
   localparam int SLOTS = kde_pkg::SAMPLE_SLOTS;

   kde_pkg::tag_type  tag_ff [N];
   kde_pkg::rsp_type  rsp_ff;
   logic              rsp_valid_ff;
   logic [15:0]       thr_ff;
   logic              upd_ff;
   logic [3:0]        rslot_ff;
   logic [15:0]       weight_ff [SLOTS];

   kde_pkg::store_wr_type wr;
   logic [7:0]  rd_sample [SLOTS];
   logic [7:0]  rd_median;
   logic [7:0]  m_fix;
   logic [kde_pkg::TERM_W-1:0] term [SLOTS];
   logic [15:0] dens;

   logic adv, accept, busy, hazard, req_pix_ok, req_slot_ok;
   logic cls_last, fg_last, repl, wb_we, ld_smp_we;
   kde_pkg::tag_type last;

   assign adv  = !rsp_valid_ff || !rsp_stall;
   assign last = tag_ff[N-1];

   always_comb begin
      busy   = 1'b0;
      hazard = 1'b0;
      for (int k = 0; k < N; k++) begin
         busy   = busy | tag_ff[k].valid;
         hazard = hazard | (tag_ff[k].valid && tag_ff[k].op == kde_pkg::OP_CLASSIFY &&
                            tag_ff[k].pix == req_item.pixel_index);
      end
   end

   assign req_pix_ok  = 32'(req_item.pixel_index) < 32'(kde_pkg::PIXEL_COUNT);
   assign req_slot_ok = 32'(req_item.slot) < 32'(SLOTS);

   assign cls_last = last.valid && last.op == kde_pkg::OP_CLASSIFY && last.pix_ok;
   assign fg_last  = dens <= thr_ff;
   assign repl     = cls_last && !fg_last && upd_ff && (32'(rslot_ff) < 32'(SLOTS));
   assign wb_we    = adv && repl;

   assign req_stall = !adv || hazard ||
                      (req_item.op == kde_pkg::OP_WEIGHT && busy) ||
                      (req_item.op == kde_pkg::OP_SAMPLE && repl);
   assign accept    = req_valid && !req_stall;
   assign ld_smp_we = accept && req_item.op == kde_pkg::OP_SAMPLE && req_pix_ok && req_slot_ok;

   always_comb begin
      wr.smp_we   = wb_we || ld_smp_we;
      wr.smp_slot = wb_we ? kde_pkg::SLOT_W'(rslot_ff) : kde_pkg::SLOT_W'(req_item.slot);
      wr.smp_addr = wb_we ? last.pix[kde_pkg::PIX_AW-1:0] :
                            req_item.pixel_index[kde_pkg::PIX_AW-1:0];
      wr.smp_data = wb_we ? last.value : req_item.pixel_value;
      wr.med_we   = accept && req_item.op == kde_pkg::OP_MEDIAN && req_pix_ok;
      wr.med_addr = req_item.pixel_index[kde_pkg::PIX_AW-1:0];
      wr.med_data = req_item.median_value;
   end

   kde_sample_store u_store (
      .clock     (clock),
      .rd_en     (adv),
      .rd_addr   (req_item.pixel_index[kde_pkg::PIX_AW-1:0]),
      .wr        (wr),
      .rd_sample (rd_sample),
      .rd_median (rd_median)
   );

   // a zero median counts as one
   assign m_fix = (rd_median == 8'd0) ? 8'd1 : rd_median;

   for (genvar i = 0; i < SLOTS; i++) begin : g_lane
      kde_lane u_lane (
         .clock  (clock),
         .en     (adv),
         .value  (tag_ff[0].value),
         .sample (rd_sample[i]),
         .med    (m_fix),
         .weight (weight_ff[i]),
         .term   (term[i])
      );
   end

   kde_density u_density (
      .clock (clock),
      .en    (adv),
      .term  (term),
      .med   (tag_ff[kde_pkg::LANE_LAT].med),
      .dens  (dens)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (adv) begin
         tag_ff[0].valid  <= accept;
         tag_ff[0].op     <= req_item.op;
         tag_ff[0].pix    <= req_item.pixel_index;
         tag_ff[0].value  <= req_item.pixel_value;
         tag_ff[0].med    <= req_item.median_value;
         tag_ff[0].pix_ok <= req_pix_ok;
         // from here on the tag carries the read median
         tag_ff[1]        <= {tag_ff[0].valid, tag_ff[0].op, tag_ff[0].pix,
                              tag_ff[0].value, m_fix, tag_ff[0].pix_ok};
         for (int k = 2; k < N; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // weights change only with an empty pipeline, so lanes read them directly
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (accept && req_item.op == kde_pkg::OP_WEIGHT && req_slot_ok &&
             req_item.slot == 4'(i)) begin
            weight_ff[i] <= req_item.slot_weight;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= 16'd308;
         upd_ff   <= 1'b1;
         rslot_ff <= 4'd9;
      end else if (csr_we) begin
         unique case (csr_index)
            kde_pkg::CSR_THRESHOLD: thr_ff   <= csr_wdata;
            kde_pkg::CSR_UPDATE:    upd_ff   <= csr_wdata[0];
            kde_pkg::CSR_SLOT:      rslot_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.density         <= cls_last ? dens : 16'd0;
         rsp_ff.foreground      <= cls_last && fg_last;
         rsp_ff.sample_replaced <= repl;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `KDE_ASSERT(a_weight_load_idle, (accept && req_item.op == kde_pkg::OP_WEIGHT) |-> !busy)
   `KDE_ASSERT(a_single_write, !(wb_we && ld_smp_we))
   `KDE_ASSERT(a_replace_reported, wb_we |=> (rsp_valid && rsp_item.sample_replaced))
   `KDE_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

// File: tb/tb_kde_background_pixel_classifier.sv
// Self-checking testbench for kde_background_pixel_classifier.
// Needs kde_pkg and the classifier RTL. A built-in density predictor checks every result
// under several register settings and several idle and stall patterns.
`timescale 1ns / 1ps

module tb_kde_background_pixel_classifier;

   localparam int NPIX = 16384;
   localparam int NSLOT = 10;
   localparam int POOL_N = 8;
   localparam longint unsigned HALF_SQ = 30325;
   localparam longint unsigned NORM = 25150;
   // register index past the end of the list, writes are ignored
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // exp(-2^(j-16)) in Q16
   localparam int unsigned EXP_TAB [20] = '{
      65535, 65534, 65532, 65528, 65520, 65504, 65472, 65408,
      65280, 65026, 64520, 63520, 61565, 57835, 51039, 39750,
      24109, 8869, 1200, 22};

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   kde_pkg::req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   kde_pkg::rsp_type rsp_item;
   logic    csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   kde_background_pixel_classifier u_dut (.*);

   always #4 clock = ~clock;

   // shadow state of the block
   logic [7:0]  sample_mem [0:NPIX*NSLOT-1];
   logic [7:0]  median_mem [0:NPIX-1];
   logic [15:0] weight_mem [0:NSLOT-1];
   logic [15:0] thresh_reg = 16'd308;
   logic        update_reg = 1'b1;
   logic [3:0]  repl_reg = 4'd9;

   kde_pkg::rsp_type expected_rsp_q [$];
   logic [13:0]  pixel_pool [POOL_N];
   int           idle_pct = 0;
   int           stall_pct = 0;
   bit           failed = 0;

   function automatic longint unsigned kernel_q16(longint unsigned x);
      longint unsigned acc;
      acc = 65536;
      if (x >= (64'd16 << 16)) return 0;
      for (int j = 0; j < 20; j++)
         if (x[j]) acc = (acc * 64'(EXP_TAB[j]) + 32768) >> 16;
      return acc;
   endfunction

   function automatic kde_pkg::rsp_type predict_density(kde_pkg::req_type it);
      kde_pkg::rsp_type r;
      longint unsigned m, m2, sum, d, x, dens, pv, sv;
      int base;
      r = '0;
      case (it.op)
         kde_pkg::OP_SAMPLE: if (int'(it.slot) < NSLOT)
            sample_mem[int'(it.pixel_index) * NSLOT + int'(it.slot)] = it.pixel_value;
         kde_pkg::OP_MEDIAN: median_mem[it.pixel_index] = it.median_value;
         kde_pkg::OP_WEIGHT: if (int'(it.slot) < NSLOT) weight_mem[it.slot] = it.slot_weight;
         default: begin
            base = int'(it.pixel_index) * NSLOT;
            m = 64'(median_mem[it.pixel_index]);
            if (m == 0) m = 1;
            m2 = m * m;
            sum = 0;
            pv = 64'(it.pixel_value);
            for (int i = 0; i < NSLOT; i++) begin
               sv = 64'(sample_mem[base+i]);
               d = (pv >= sv) ? pv - sv : sv - pv;
               x = (d * d * HALF_SQ + m2 / 2) / m2;
               sum += 64'(weight_mem[i]) * kernel_q16(x) * NORM;
            end
            dens = (sum + (m << 31)) / (m << 32);
            if (dens > 65535) dens = 65535;
            r.density = dens[15:0];
            r.foreground = (dens <= 64'(thresh_reg));
            if (!r.foreground && update_reg && int'(repl_reg) < NSLOT) begin
               sample_mem[base + int'(repl_reg)] = it.pixel_value;
               r.sample_replaced = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_item(kde_pkg::req_type it);
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(predict_density(it));
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         kde_pkg::CSR_THRESHOLD: thresh_reg = val;
         kde_pkg::CSR_UPDATE:    update_reg = val[0];
         kde_pkg::CSR_SLOT:      repl_reg = val[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic kde_pkg::req_type rand_fields();
      kde_pkg::req_type it;
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      it = bits[$bits(kde_pkg::req_type)-1:0];
      return it;
   endfunction

   task automatic send_load(logic [1:0] op, int pix, int slot, int val);
      kde_pkg::req_type it;
      it = rand_fields();
      it.op = op;
      it.pixel_index = 14'(pix);
      it.slot = 4'(slot);
      it.pixel_value = 8'(val);
      it.median_value = 8'(val);
      it.slot_weight = 16'(val);
      send_item(it);
   endtask

   task automatic send_classify(int pix, int val);
      kde_pkg::req_type it;
      it = rand_fields();
      it.op = kde_pkg::OP_CLASSIFY;
      it.pixel_index = 14'(pix);
      it.pixel_value = 8'(val);
      send_item(it);
   endtask

   // pixel value close to one of the stored samples, so background is likely
   function automatic int near_value(int pix);
      int v;
      v = int'(sample_mem[pix * NSLOT + int'($urandom_range(NSLOT-1))]) +
          int'($urandom_range(6)) - 3;
      return (v < 0) ? 0 : (v > 255) ? 255 : v;
   endfunction

   task automatic test_setup();
      pixel_pool[0] = 14'd0;
      pixel_pool[1] = 14'h3FFF;
      pixel_pool[2] = 14'h2AAA;
      pixel_pool[3] = 14'h1555;
      for (int p = 4; p < POOL_N; p++) pixel_pool[p] = 14'($urandom_range(NPIX-1));
      for (int s = 0; s < NSLOT; s++)
         send_load(kde_pkg::OP_WEIGHT, int'($urandom), s, int'($urandom_range(65535)));
      for (int p = 0; p < POOL_N; p++) begin
         send_load(kde_pkg::OP_MEDIAN, int'(pixel_pool[p]), int'($urandom),
                   (p == 0) ? 0 : int'($urandom_range(1, 40)));
         for (int s = 0; s < NSLOT; s++)
            send_load(kde_pkg::OP_SAMPLE, int'(pixel_pool[p]), s, int'($urandom_range(255)));
      end
      wait_idle();
   endtask

   task automatic test_directed();
      // extreme weights, ignored loads to slots past the end, zero median pixel
      send_load(kde_pkg::OP_WEIGHT, 0, 0, 65535);
      send_load(kde_pkg::OP_WEIGHT, 0, 9, 0);
      send_load(kde_pkg::OP_WEIGHT, 16383, 15, 1234);
      send_load(kde_pkg::OP_SAMPLE, int'(pixel_pool[1]), 12, 77);
      send_load(kde_pkg::OP_SAMPLE, int'(pixel_pool[1]), 0, 255);
      send_load(kde_pkg::OP_SAMPLE, int'(pixel_pool[1]), 9, 0);
      send_load(kde_pkg::OP_MEDIAN, int'(pixel_pool[1]), 0, 255);
      send_classify(int'(pixel_pool[0]), 0);
      send_classify(int'(pixel_pool[0]), 255);
      send_classify(int'(pixel_pool[0]), near_value(int'(pixel_pool[0])));
      send_classify(int'(pixel_pool[1]), 255);
      send_classify(int'(pixel_pool[1]), 0);
      send_classify(int'(pixel_pool[1]), 128);
      send_load(kde_pkg::OP_MEDIAN, int'(pixel_pool[1]), 0, 1);
      send_classify(int'(pixel_pool[1]), 255);
      for (int p = 2; p < POOL_N; p++)
         send_classify(int'(pixel_pool[p]), near_value(int'(pixel_pool[p])));
      wait_idle();
   endtask

   task automatic random_item();
      int k, p;
      k = int'($urandom_range(99));
      p = int'(pixel_pool[$urandom_range(POOL_N-1)]);
      if (k < 70)
         send_classify(p, ($urandom_range(2) != 0) ? near_value(p) : int'($urandom_range(255)));
      else if (k < 82)
         send_load(kde_pkg::OP_SAMPLE,
                   ($urandom_range(3) == 0) ? int'($urandom_range(NPIX-1)) : p,
                   int'($urandom_range(15)), int'($urandom_range(255)));
      else if (k < 92)
         send_load(kde_pkg::OP_MEDIAN,
                   ($urandom_range(3) == 0) ? int'($urandom_range(NPIX-1)) : p, 0,
                   ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 60)));
      else
         send_load(kde_pkg::OP_WEIGHT, 0, int'($urandom_range(15)),
                   int'($urandom_range(65535)));
   endtask

   task automatic test_config_sweep();
      logic [15:0] thr [4] = '{16'd0, 16'd65535, 16'd308, 16'd2000};
      for (int c = 0; c < 4; c++) begin
         write_csr(kde_pkg::CSR_THRESHOLD, thr[c]);
         write_csr(kde_pkg::CSR_UPDATE, c[0] ? 16'hFFFE : 16'h0001);
         write_csr(kde_pkg::CSR_SLOT,
                   (c == 1) ? 16'd0 : (c == 2) ? 16'd12 : (c == 3) ? 16'd9 : 16'd4);
         write_csr(CSR_UNUSED, 16'($urandom));
         repeat (25) random_item();
         wait_idle();
      end
      write_csr(kde_pkg::CSR_UPDATE, 16'd1);
      write_csr(kde_pkg::CSR_THRESHOLD, 16'd400);
      write_csr(kde_pkg::CSR_SLOT, 16'd15);
      repeat (10) random_item();
      wait_idle();
      write_csr(kde_pkg::CSR_SLOT, 16'd2);
   endtask

   task automatic test_random_idling();
      int idle_set [4] = '{0, 80, 0, 34};
      int stall_set [4] = '{0, 0, 80, 34};
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_set[ph];
         stall_pct = stall_set[ph];
         for (int n = 0; n < 60; n++) begin
            random_item();
            if (n % 20 == 0 && n > 0) begin
               wait_idle();
               write_csr(kde_pkg::CSR_THRESHOLD, 16'($urandom_range(50, 3000)));
            end
         end
         wait_idle();
         write_csr(kde_pkg::CSR_THRESHOLD, 16'($urandom_range(50, 3000)));
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      kde_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected item, actual %h", $time, rsp_item);
            failed = 1;
         end else begin
            exp_r = expected_rsp_q.pop_front();
            if (rsp_item.density !== exp_r.density) begin
               $display("%0t: density expected %0d actual %0d", $time, exp_r.density,
                        rsp_item.density);
               failed = 1;
            end
            if (rsp_item.foreground !== exp_r.foreground) begin
               $display("%0t: foreground expected %b actual %b", $time, exp_r.foreground,
                        rsp_item.foreground);
               failed = 1;
            end
            if (rsp_item.sample_replaced !== exp_r.sample_replaced) begin
               $display("%0t: sample_replaced expected %b actual %b", $time,
                        exp_r.sample_replaced, rsp_item.sample_replaced);
               failed = 1;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_setup();
      test_directed();
      test_config_sweep();
      test_random_idling();
      wait_idle();
      if (!failed && expected_rsp_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #8ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
